/* hdl/fscl_pkg.sv */
`default_nettype none

package fscl_pkg;

  localparam logic [1:0] REQ_START     = 2'd0;
  localparam logic [1:0] REQ_DATA      = 2'd1;
  localparam logic [1:0] REQ_POLL      = 2'd2;
  localparam logic [1:0] REQ_WAIT_DONE = 2'd3;

  localparam logic [1:0] PHASE_IDLE      = 2'd0;
  localparam logic [1:0] PHASE_WAIT_INIT = 2'd1;
  localparam logic [1:0] PHASE_WAIT_DONE = 2'd2;

  localparam logic [1:0] STATUS_PIN     = 2'd0;
  localparam logic [1:0] STATUS_OK      = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  localparam logic [15:0] MAX_POLLS_RESET = 16'd1000;

  // Index of the result within one item: 0..16
  localparam int unsigned STEP_W = 5;
  localparam logic [3:0] LAST_BIT_STEP = 4'd15;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       end_of_block;
    logic       init_pin_level;
    logic       done_pin_level;
  } in_item_t;

  typedef struct packed {
    logic       program_level;
    logic       clock_level;
    logic       serial_data;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic program_level;
    logic clock_level;
    logic serial_data;
  } pins_t;

endpackage

`default_nettype wire

/* hdl/fscl_seq.sv */
`default_nettype none

module fscl_seq
  import fscl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  input  wire logic [15:0] max_polls_i,
  output logic             push_o,
  output out_item_t        result_o,
  input  wire logic        ready_i
);

  logic              item_valid_q;
  in_item_t          item_q;
  logic [STEP_W-1:0] step_q;
  pins_t             pins_q, pins_d;
  logic [1:0]        phase_q, phase_d;
  logic [15:0]       poll_q, poll_d;
  logic [15:0]       poll_inc;
  logic [15:0]       limit;
  logic              emit, done, fire, ok, accept;
  logic [1:0]        status;

  assign poll_inc = poll_q + 16'd1;
  assign limit    = (max_polls_i == 16'd0) ? 16'd1 : max_polls_i;

  always_comb begin
    emit    = 1'b0;
    done    = 1'b0;
    ok      = 1'b0;
    status  = STATUS_PIN;
    pins_d  = pins_q;
    phase_d = phase_q;
    poll_d  = poll_q;
    case (item_q.req_type)
      REQ_START: begin
        emit = 1'b1;
        pins_d.clock_level = 1'b0;
        if (step_q == '0) begin
          pins_d.program_level = 1'b0;
        end else begin
          pins_d.program_level = 1'b1;
          done    = 1'b1;
          phase_d = PHASE_WAIT_INIT;
          poll_d  = '0;
        end
      end
      REQ_DATA: begin
        emit = 1'b1;
        if (step_q[STEP_W-1]) begin
          // trailing CCLK low after the block's last byte
          pins_d.clock_level = 1'b0;
          done = 1'b1;
        end else begin
          pins_d.serial_data = item_q.data_byte[3'd7 - step_q[3:1]];
          pins_d.clock_level = step_q[0];
          done = (step_q[3:0] == LAST_BIT_STEP) && !item_q.end_of_block;
        end
      end
      REQ_WAIT_DONE: begin
        done    = 1'b1;
        phase_d = PHASE_WAIT_DONE;
        poll_d  = '0;
      end
      REQ_POLL: begin
        done = 1'b1;
        if (phase_q == PHASE_WAIT_INIT || phase_q == PHASE_WAIT_DONE) begin
          ok = (phase_q == PHASE_WAIT_INIT) ? !item_q.init_pin_level
                                            : item_q.done_pin_level;
          if (ok) begin
            emit    = 1'b1;
            status  = STATUS_OK;
            phase_d = PHASE_IDLE;
            poll_d  = '0;
          end else if (poll_inc >= limit) begin
            emit    = 1'b1;
            status  = STATUS_TIMEOUT;
            phase_d = PHASE_IDLE;
            poll_d  = '0;
          end else begin
            poll_d = poll_inc;
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign fire       = item_valid_q && (!emit || ready_i);
  assign in_stall_o = item_valid_q && !(fire && done);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = fire && emit;

  assign result_o.program_level = pins_d.program_level;
  assign result_o.clock_level   = pins_d.clock_level;
  assign result_o.serial_data   = pins_d.serial_data;
  assign result_o.status        = status;
  assign result_o.last          = done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= '0;
      phase_q      <= PHASE_IDLE;
      poll_q       <= '0;
      pins_q       <= '{program_level: 1'b1, clock_level: 1'b0, serial_data: 1'b0};
    end else begin
      if (fire) begin
        pins_q  <= pins_d;
        phase_q <= phase_d;
        poll_q  <= poll_d;
        step_q  <= done ? '0 : step_q + STEP_W'(1);
      end
      if (accept) begin
        item_valid_q <= 1'b1;
        step_q       <= '0;
      end else if (fire && done) begin
        item_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/fscl_out_reg.sv */
`default_nettype none

module fscl_out_reg
  import fscl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire out_item_t result_i,
  output logic           ready_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  logic      valid_q;
  out_item_t data_q;

  // take a new result when empty or when the held one leaves this cycle
  assign ready_o     = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire

/* hdl/fpga_serial_config_loader.sv */
// Serial FPGA configuration loader: turns requests into PROGRAM_B/CCLK/DIN
// pin states and poll results.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one request per
// transfer. Output channel (out_valid_o / out_stall_i / out_data_o): one
// pin state or wait status per transfer; last marks the final one of a
// request. Config: cfg_wen_i writes max_polls from cfg_wdata_i; the user
// must do so only while idle; the block itself does not enforce this.
// The request is registered in the sequencer, each result again in the
// output register. Throughput: one result per cycle while the output does
// not stall; a data byte gives CCLK low then high per bit, MSB first, plus
// a trailing CCLK low with end_of_block, and a start PROGRAM_B low then
// high. The next request is taken in the cycle its predecessor takes its
// final step; the sequencer step counter sets the rate. Stalls on the
// output hold its register and freeze result steps, stalling the input.
//
// Reset: idle, poll count zero, PROGRAM_B high, CCLK and DIN low,
// max_polls 1000. No clearing pass is needed.
`default_nettype none

module fpga_serial_config_loader
  import fscl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_wen_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_item_t        out_data_o
);

  logic [15:0] max_polls_q;
  logic        push;
  logic        ready;
  out_item_t   result;

  // Hold the poll limit; the user must write it only while no request is in flight (not enforced here)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_polls_q <= MAX_POLLS_RESET;
    end else if (cfg_wen_i) begin
      max_polls_q <= cfg_wdata_i;
    end
  end

  // Advance through the pin states of the current request
  fscl_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .max_polls_i (max_polls_q),
    .push_o      (push),
    .result_o    (result),
    .ready_i     (ready)
  );

  // Hold each result until the receiver takes it
  fscl_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .result_i    (result),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* hdl/fscl_checker.sv */
`default_nettype none

module fscl_checker
  import fscl_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // wait results are single-result requests
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_PIN) |-> out_data_o.last)
    else $error("wait status on a non-final result");

  // CCLK only rises with PROGRAM_B released
  a_clk_prog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clock_level |-> out_data_o.program_level)
    else $error("CCLK high while PROGRAM_B low");

  // the PROGRAM_B low pulse is never the end of a request
  a_prog_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.program_level |->
      !out_data_o.last && !out_data_o.clock_level)
    else $error("PROGRAM_B low on a final result");

endmodule

bind fpga_serial_config_loader fscl_checker u_fscl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

/* bench/fpga_serial_config_loader_test.sv */
`default_nettype none

module fpga_serial_config_loader_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fscl_pkg::*;

  // Slowest legal run: about 360 requests, at most 17 pin states each, every
  // state held by a heavy receiver stall. That stays well under CYCLE_LIMIT.
  localparam int unsigned CYCLE_LIMIT  = 300_000;
  // Let a trailing no-result request finish after the queues drain.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned SEGMENT_REQS  = 55;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wen_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;

  fpga_serial_config_loader dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wen_i   (cfg_wen_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Requests waiting for the driver, and pin states the loader still owes us.
  in_item_t  requests_to_send[$];
  out_item_t expected_pin_states[$];

  int unsigned requests_queued = 0;
  int unsigned requests_taken  = 0;
  int unsigned error_count     = 0;
  int unsigned cycle_count     = 0;

  // 0: sender gaps 32%, receiver stalls 69%; 1: the other way round; 2: none.
  int unsigned gap_mode = 0;

  // Shadow of the loader: pins, wait phase, failed poll count, max_polls.
  pins_t       pin_state      = '{program_level: 1'b1, clock_level: 1'b0, serial_data: 1'b0};
  logic [1:0]  wait_phase     = PHASE_IDLE;
  logic [15:0] failed_polls   = '0;
  logic [15:0] max_polls_cfg  = MAX_POLLS_RESET;

  // Hold back the newest pin state so the last one of a request gets its flag.
  out_item_t   staged_result;
  bit          result_staged = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: no progress, giving up", $realtime);
      $display("fpga_serial_config_loader_test failed");
      $finish;
    end
  end

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic bit sender_gap();
    case (gap_mode)
      0:       return $urandom_range(99) < 32;
      1:       return $urandom_range(99) < 69;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_gap();
    case (gap_mode)
      0:       return $urandom_range(99) < 69;
      1:       return $urandom_range(99) < 32;
      default: return 1'b0;
    endcase
  endfunction

  // Snapshot the current pins with a status, pushing the previous snapshot.
  task automatic stage_result(input logic [1:0] status);
    if (result_staged) expected_pin_states.push_back(staged_result);
    staged_result = {pin_state, status, 1'b0};
    result_staged = 1'b1;
  endtask

  // Advance the shadow loader by one accepted request and record the pin
  // states it must produce.
  task automatic predict_pin_states(input in_item_t req);
    int          bit_idx;
    logic        pin_ok;
    logic [15:0] poll_limit;
    case (req.req_type)
      REQ_START: begin
        // Pulse PROGRAM_B low, release it, then wait for INT_B low.
        pin_state.program_level = 1'b0;
        pin_state.clock_level   = 1'b0;
        stage_result(STATUS_PIN);
        pin_state.program_level = 1'b1;
        stage_result(STATUS_PIN);
        wait_phase   = PHASE_WAIT_INIT;
        failed_polls = '0;
      end
      REQ_DATA: begin
        // MSB first: CCLK low with DIN set, then CCLK high.
        for (bit_idx = 7; bit_idx >= 0; bit_idx--) begin
          pin_state.serial_data = req.data_byte[bit_idx];
          pin_state.clock_level = 1'b0;
          stage_result(STATUS_PIN);
          pin_state.clock_level = 1'b1;
          stage_result(STATUS_PIN);
        end
        if (req.end_of_block) begin
          pin_state.clock_level = 1'b0;
          stage_result(STATUS_PIN);
        end
      end
      REQ_WAIT_DONE: begin
        wait_phase   = PHASE_WAIT_DONE;
        failed_polls = '0;
      end
      default: begin
        // Poll tick: ignored while idle.
        if (wait_phase != PHASE_IDLE) begin
          pin_ok = (wait_phase == PHASE_WAIT_INIT) ? !req.init_pin_level
                                                   : req.done_pin_level;
          if (pin_ok) begin
            stage_result(STATUS_OK);
            wait_phase   = PHASE_IDLE;
            failed_polls = '0;
          end else begin
            // A limit of zero acts as one.
            poll_limit   = (max_polls_cfg == '0) ? 16'd1 : max_polls_cfg;
            failed_polls = failed_polls + 16'd1;
            if (failed_polls >= poll_limit) begin
              stage_result(STATUS_TIMEOUT);
              wait_phase   = PHASE_IDLE;
              failed_polls = '0;
            end
          end
        end
      end
    endcase
    if (result_staged) begin
      staged_result.last = 1'b1;
      expected_pin_states.push_back(staged_result);
      result_staged = 1'b0;
    end
  endtask

  // Driver: present queued requests, hold a stalled one, and predict each
  // transfer at the edge where it happens.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin : drive
      bit busy;
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        predict_pin_states(in_data_i);
        requests_taken++;
        busy = 1'b0;
      end
      // Only touch valid once per edge; a stalled payload stays put.
      if (!busy) begin
        if (requests_to_send.size() != 0 && !sender_gap()) begin
          in_data_i  <= requests_to_send.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every output transfer against the oldest prediction, and
  // throttle the output channel.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin : observe
      out_item_t want;
      if (out_valid_o && !out_stall_i) begin
        if (expected_pin_states.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result: expected none, got prog=%b cclk=%b din=%b status=%0d last=%b",
                   $realtime, out_data_o.program_level, out_data_o.clock_level,
                   out_data_o.serial_data, out_data_o.status, out_data_o.last);
        end else begin
          want = expected_pin_states.pop_front();
          if (out_data_o !== want) begin
            error_count++;
            $display("%0t: mismatch: expected prog=%b cclk=%b din=%b status=%0d last=%b",
                     $realtime, want.program_level, want.clock_level,
                     want.serial_data, want.status, want.last);
            $display("%0t:           actual prog=%b cclk=%b din=%b status=%0d last=%b",
                     $realtime, out_data_o.program_level, out_data_o.clock_level,
                     out_data_o.serial_data, out_data_o.status, out_data_o.last);
          end
        end
      end
      out_stall_i <= receiver_gap();
    end
  end

  task automatic queue_request(input logic [1:0] req_type, input logic [7:0] data_byte,
                               input logic eob, input logic init_lvl,
                               input logic done_lvl);
    in_item_t req;
    req.req_type       = req_type;
    req.data_byte      = data_byte;
    req.end_of_block   = eob;
    req.init_pin_level = init_lvl;
    req.done_pin_level = done_lvl;
    requests_to_send.push_back(req);
    requests_queued++;
  endtask

  task automatic queue_random_byte();
    queue_request(REQ_DATA, 8'($urandom_range(255)), rand_bit(), rand_bit(), rand_bit());
  endtask

  // Mostly well-formed programming flows with random content, some noise.
  task automatic queue_random_sequence();
    int unsigned kind;
    int unsigned fails;
    int unsigned k;
    kind = $urandom_range(99);
    if (kind < 35) begin
      // Start, a few INT_B-high polls with bytes mixed in, then maybe INT_B low.
      queue_request(REQ_START, 8'($urandom_range(255)), rand_bit(), rand_bit(), rand_bit());
      fails = $urandom_range(6);
      for (k = 0; k < fails; k++) begin
        if ($urandom_range(3) == 0) queue_random_byte();
        queue_request(REQ_POLL, 8'($urandom_range(255)), rand_bit(), 1'b1, rand_bit());
      end
      if ($urandom_range(9) < 7)
        queue_request(REQ_POLL, 8'($urandom_range(255)), rand_bit(), 1'b0, rand_bit());
    end else if (kind < 70) begin
      fails = $urandom_range(1, 4);
      for (k = 0; k < fails; k++) queue_random_byte();
    end else if (kind < 85) begin
      // Wait for DONE: some DONE-low polls, then maybe DONE high.
      queue_request(REQ_WAIT_DONE, 8'($urandom_range(255)), rand_bit(), rand_bit(),
                    rand_bit());
      fails = $urandom_range(6);
      for (k = 0; k < fails; k++)
        queue_request(REQ_POLL, 8'($urandom_range(255)), rand_bit(), rand_bit(), 1'b0);
      if ($urandom_range(9) < 7)
        queue_request(REQ_POLL, 8'($urandom_range(255)), rand_bit(), rand_bit(), 1'b1);
    end else begin
      fails = $urandom_range(1, 3);
      for (k = 0; k < fails; k++)
        queue_request(2'($urandom_range(3)), 8'($urandom_range(255)), rand_bit(),
                      rand_bit(), rand_bit());
    end
  endtask

  // Block until every queued request was taken and every pin state seen,
  // then let a trailing no-result request finish inside the loader.
  task automatic wait_until_quiet();
    @(posedge clk_i);
    while (requests_taken != requests_queued || expected_pin_states.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write max_polls while the loader is idle; track it in the shadow.
  task automatic write_max_polls(input logic [15:0] value);
    @(posedge clk_i);
    cfg_wen_i     <= 1'b1;
    cfg_wdata_i   <= value;
    max_polls_cfg  = value;
    @(posedge clk_i);
    cfg_wen_i     <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned seg;
    int unsigned target;
    logic [15:0] seg_limit;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed flows at the reset max_polls.
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b0, 1'b1);  // poll while idle: dropped
    queue_request(REQ_START,     8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b1, 1'b0);  // INT_B still high
    queue_request(REQ_DATA,      8'h00, 1'b0, 1'b1, 1'b1);  // byte inside a wait
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b0, 1'b0);  // INT_B low: success
    queue_request(REQ_DATA,      8'hFF, 1'b1, 1'b0, 1'b0);
    queue_request(REQ_DATA,      8'hA5, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_DATA,      8'h5A, 1'b1, 1'b0, 1'b0);
    queue_request(REQ_WAIT_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b0, 1'b0);  // DONE still low
    queue_request(REQ_START,     8'h00, 1'b0, 1'b0, 1'b0);  // start replaces the wait
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b1, 1'b1);  // DONE high is not awaited
    queue_request(REQ_WAIT_DONE, 8'h00, 1'b0, 1'b0, 1'b0);  // replace again
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b1, 1'b1);  // DONE high: success
    queue_request(REQ_START,     8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_START,     8'h00, 1'b0, 1'b0, 1'b0);  // back-to-back start
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b0, 1'b1);  // idle again: dropped
    queue_request(REQ_DATA,      8'h80, 1'b1, 1'b0, 1'b0);
    queue_request(REQ_DATA,      8'h01, 1'b0, 1'b0, 1'b0);
    wait_until_quiet();

    // Timeout on the very first failed poll, at max_polls one and zero.
    write_max_polls(16'd1);
    queue_request(REQ_START,     8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b1, 1'b0);
    wait_until_quiet();
    write_max_polls(16'd0);
    queue_request(REQ_WAIT_DONE, 8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_START,     8'h00, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_POLL,      8'h00, 1'b0, 1'b0, 1'b0);

    // Random flows in segments, each with its own max_polls; switch the
    // gap pattern every two segments.
    for (seg = 0; seg < 6; seg++) begin
      wait_until_quiet();
      gap_mode = seg / 2;
      case (seg)
        0:       seg_limit = 16'hFFFF;
        1:       seg_limit = 16'd3;
        2:       seg_limit = 16'd1;
        3:       seg_limit = 16'd0;
        4:       seg_limit = 16'($urandom_range(2, 8));
        default: seg_limit = MAX_POLLS_RESET;
      endcase
      write_max_polls(seg_limit);
      target = requests_queued + SEGMENT_REQS;
      while (requests_queued < target) queue_random_sequence();
    end

    wait_until_quiet();
    if (expected_pin_states.size() != 0) begin
      error_count++;
      $display("%0t: %0d pin states never arrived", $realtime, expected_pin_states.size());
    end
    if (error_count == 0) begin
      $display("fpga_serial_config_loader_test passed");
    end else begin
      $display("fpga_serial_config_loader_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hdl/fscl_pkg.sv
hdl/fscl_seq.sv
hdl/fscl_out_reg.sv
hdl/fpga_serial_config_loader.sv
hdl/fscl_checker.sv
bench/fpga_serial_config_loader_test.sv
